@@ rtl/core/stbs_pkg.sv @@
`default_nettype none

package stbs_pkg;

   // Table geometry.
   localparam int TableDepth = 256;
   localparam int AddrWidth  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int DataWidth  = 32;
   localparam int IndexWidth = 8;
   // Search bounds run from -1 up to 2**IndexWidth, so they carry a sign and a spare bit.
   localparam int BoundWidth = IndexWidth + 2;

   // Request kinds.
   localparam logic ReqWrite  = 1'b0;
   localparam logic ReqSearch = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      StIdle   = 2'b01,
      StSearch = 2'b10
   } state_type;

   // Outcome of one probe, handed from the compare unit to the sequencer.
   typedef struct packed {
      logic                         hit;
      logic                         more;
      logic signed [BoundWidth-1:0] lo_next;
      logic signed [BoundWidth-1:0] hi_next;
      logic [IndexWidth-1:0]        mid_next;
   } probe_type;

endpackage

`default_nettype wire

@@ rtl/core/stbs_if.sv @@
`default_nettype none

// Request channel: write one entry or search for a key.
interface stbs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic [stbs_pkg::IndexWidth-1:0]      entry_index;
   logic signed [stbs_pkg::DataWidth-1:0] entry_value;
   logic signed [stbs_pkg::DataWidth-1:0] search_key;
   logic [stbs_pkg::IndexWidth-1:0]      range_low;
   logic [stbs_pkg::IndexWidth-1:0]      range_high;

   modport source (
      output valid, req_type, entry_index, entry_value, search_key, range_low, range_high,
      input  ready
   );
   modport sink (
      input  valid, req_type, entry_index, entry_value, search_key, range_low, range_high,
      output ready
   );
endinterface

// Response channel: one per search request.
interface stbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [stbs_pkg::IndexWidth-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

@@ rtl/core/stbs_ram.sv @@
`default_nettype none

// Simple RAM: one write port, one read port with registered data.
module stbs_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                         wr_data,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                              rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/stbs_probe.sv @@
`default_nettype none

// Compare unit: checks one probed entry against the key and narrows the bounds.
module stbs_probe (
   input  wire logic signed [stbs_pkg::BoundWidth-1:0] lo,
   input  wire logic signed [stbs_pkg::BoundWidth-1:0] hi,
   input  wire logic [stbs_pkg::IndexWidth-1:0]        mid,
   input  wire logic                                   in_range,
   input  wire logic signed [stbs_pkg::DataWidth-1:0]  rd_data,
   input  wire logic signed [stbs_pkg::DataWidth-1:0]  key,
   output stbs_pkg::probe_type                         result
);

   logic signed [stbs_pkg::DataWidth-1:0]  value;
   logic signed [stbs_pkg::BoundWidth-1:0] mid_wide;
   logic signed [stbs_pkg::BoundWidth-1:0] sum;

   // An index past the end of the table reads as zero.
   assign value    = in_range ? rd_data : '0;
   assign mid_wide = stbs_pkg::BoundWidth'({1'b0, mid});

   always_comb begin
      result.hit     = (value == key);
      result.lo_next = lo;
      result.hi_next = hi;
      if (!result.hit) begin
         if (value > key) begin
            result.hi_next = mid_wide - stbs_pkg::BoundWidth'(1);
         end else begin
            result.lo_next = mid_wide + stbs_pkg::BoundWidth'(1);
         end
      end
      result.more = !result.hit && (result.lo_next <= result.hi_next);
      // When the search goes on both bounds lie in the index range, so the sum is not negative.
      sum = result.lo_next + result.hi_next;
      result.mid_next = sum[stbs_pkg::IndexWidth:1];
   end

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_binary_search_top.sv @@
`default_nettype none

// Binary search over a table of signed 32-bit entries held in an internal RAM. A write
// request stores one entry and gives no response. A search request, once taken, also
// starts the first table read at the midpoint of its range; after that each probe runs
// through the loop of the RAM's registered read port and the compare unit, and a search
// makes 1 to 9 probes on a 256-entry table (at most floor(log2(range size)) + 1). The
// response then sits in an output register while the block already takes the next
// request; a search that ends while an earlier response is still unclaimed waits for it.
// Entries must be written before a search probes them. An empty or inverted range still
// probes its midpoint once. When the key is not found, position is 0.
module sorted_table_binary_search_top (
   input  wire logic clock,
   input  wire logic reset,
   stbs_req_if.sink  req_chan,
   stbs_rsp_if.source rsp_chan
);

   stbs_pkg::state_type                     state_ff, state_in;
   logic signed [stbs_pkg::BoundWidth-1:0]  lo_ff, lo_in;
   logic signed [stbs_pkg::BoundWidth-1:0]  hi_ff, hi_in;
   logic [stbs_pkg::IndexWidth-1:0]         mid_ff, mid_in;
   logic signed [stbs_pkg::DataWidth-1:0]   key_ff, key_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    found_ff, found_in;
   logic [stbs_pkg::IndexWidth-1:0]         position_ff, position_in;

   logic                                    req_fire;
   logic                                    wr_en;
   logic [stbs_pkg::AddrWidth-1:0]          rd_addr;
   logic [stbs_pkg::DataWidth-1:0]          rd_data;
   logic [stbs_pkg::IndexWidth:0]           first_sum;
   logic [stbs_pkg::IndexWidth-1:0]         first_mid;
   logic                                    mid_in_range;
   logic                                    slot_free;
   stbs_pkg::probe_type                     probe;

   assign req_chan.ready = (state_ff == stbs_pkg::StIdle);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;

   // Writes land only at indexes inside the table.
   assign wr_en = req_fire && (req_chan.req_type == stbs_pkg::ReqWrite) &&
                  (32'(req_chan.entry_index) < 32'(stbs_pkg::TableDepth));

   // Midpoint of a fresh range.
   assign first_sum = {1'b0, req_chan.range_low} + {1'b0, req_chan.range_high};
   assign first_mid = first_sum[stbs_pkg::IndexWidth:1];

   assign mid_in_range = (32'(mid_ff) < 32'(stbs_pkg::TableDepth));

   stbs_ram #(
      .Width(stbs_pkg::DataWidth),
      .Depth(stbs_pkg::TableDepth)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stbs_pkg::AddrWidth'(req_chan.entry_index)),
      .wr_data (req_chan.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stbs_probe u_probe (
      .lo       (lo_ff),
      .hi       (hi_ff),
      .mid      (mid_ff),
      .in_range (mid_in_range),
      .rd_data  (rd_data),
      .key      (key_ff),
      .result   (probe)
   );

   // Sequencer: one probe per cycle, the next read address follows from this probe.
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      found_in     = found_ff;
      position_in  = position_ff;
      rd_addr      = stbs_pkg::AddrWidth'(mid_ff);
      case (state_ff)
         stbs_pkg::StIdle: begin
            rd_addr = stbs_pkg::AddrWidth'(first_mid);
            if (req_fire && (req_chan.req_type == stbs_pkg::ReqSearch)) begin
               lo_in    = stbs_pkg::BoundWidth'(req_chan.range_low);
               hi_in    = stbs_pkg::BoundWidth'(req_chan.range_high);
               mid_in   = first_mid;
               key_in   = req_chan.search_key;
               state_in = stbs_pkg::StSearch;
            end
         end
         stbs_pkg::StSearch: begin
            if (probe.more) begin
               lo_in   = probe.lo_next;
               hi_in   = probe.hi_next;
               mid_in  = probe.mid_next;
               rd_addr = stbs_pkg::AddrWidth'(probe.mid_next);
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               found_in     = probe.hit;
               position_in  = probe.hit ? mid_ff : '0;
               state_in     = stbs_pkg::StIdle;
            end
         end
         default: begin
            state_in = stbs_pkg::StIdle;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbs_pkg::StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search bounds and response payload.
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.position = position_ff;

endmodule

`default_nettype wire
